// ===== rtl/gewma_pkg.sv =====
`timescale 1ns / 1ps
// gewma_pkg: shared widths, constants, register codes and types for the
// adaptive ewma dose-rate filter; no dependencies

package gewma_pkg;

  // field widths
  localparam int AVG_W      = 32;
  localparam int SAMPLE_W   = 16;
  localparam int ALPHA_W    = 17;
  localparam int BOOST_W    = 10;
  localparam int SENS_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // arithmetic constants
  localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'd65536;
  localparam logic [BOOST_W-1:0] BOOST_MAX  = 10'd600;
  // 60 seconds per minute times 256 for the q16.8 sensitivity
  localparam logic [13:0]        DOSE_SCALE = 14'd15360;
  localparam int                 PROD_W     = AVG_W + 14;
  localparam int                 DVD_W      = PROD_W + 1;
  localparam int                 DIV_CNT_W  = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'(DVD_W - 1);

  // register reset values
  localparam logic [SAMPLE_W-1:0] RST_RATE_THR   = 16'd100;
  localparam logic [SAMPLE_W-1:0] RST_JUMP_THR   = 16'd10;
  localparam logic [ALPHA_W-1:0]  RST_SLOW_ALPHA = 17'd1966;
  localparam logic [ALPHA_W-1:0]  RST_FAST_ALPHA = 17'd22938;
  localparam logic [BOOST_W-1:0]  RST_BOOST_LEN  = 10'd20;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATE_THR   = 3'd0,
    REG_JUMP_THR   = 3'd1,
    REG_SLOW_ALPHA = 3'd2,
    REG_FAST_ALPHA = 3'd3,
    REG_BOOST_LEN  = 3'd4,
    REG_SENS       = 3'd5
  } cfg_reg_t;

  // input action codes
  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // filter settings seen by the front part
  typedef struct packed {
    logic [SAMPLE_W-1:0] rate_thr;
    logic [SAMPLE_W-1:0] jump_thr;
    logic [ALPHA_W-1:0]  slow_alpha;
    logic [ALPHA_W-1:0]  fast_alpha;
    logic [BOOST_W-1:0]  boost_len;
  } filt_cfg_t;

  // one queued job between front and back
  typedef struct packed {
    logic [AVG_W-1:0]   average;
    logic               fast;
    logic [BOOST_W-1:0] boost;
  } dose_job_t;

endpackage

// ===== rtl/gewma_front.sv =====
`timescale 1ns / 1ps
// gewma_front: accepts items, keeps the filter state and updates the average
// depends on gewma_pkg
module gewma_front import gewma_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_action,
  input  logic [SAMPLE_W-1:0] in_count_rate,
  input  filt_cfg_t           cfg,
  output logic                q_push,
  input  logic                q_full,
  output dose_job_t           q_data
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_MULA = 5'b00010,
    F_MULB = 5'b00100,
    F_SUM  = 5'b01000,
    F_PUSH = 5'b10000
  } front_state_t;

  front_state_t        state_r, state_nxt;
  logic [AVG_W-1:0]    avg_r;
  logic [SAMPLE_W-1:0] prev_r;
  logic [BOOST_W-1:0]  cd_r;
  logic                primed_r;
  logic [SAMPLE_W-1:0] x_r;
  logic [ALPHA_W-1:0]  alpha_r;
  logic                fast_r;
  logic [48:0]         p1_r;
  logic [32:0]         p2_r;
  dose_job_t           job_r;

  logic                accept;
  logic [SAMPLE_W-1:0] diff;
  logic [BOOST_W-1:0]  blen_sat;
  logic [BOOST_W-1:0]  cd_load;
  logic                above_rate;
  logic                use_fast;
  logic [ALPHA_W-1:0]  alpha_sel;
  logic [ALPHA_W-1:0]  alpha_clamp;
  logic [49:0]         sum;

  assign accept = in_push && (state_r == F_IDLE);
  assign in_full = (state_r != F_IDLE);

  // classify the sample: jump, boost and weight choice
  always_comb begin
    diff       = (in_count_rate > prev_r) ? in_count_rate - prev_r : prev_r - in_count_rate;
    blen_sat   = (cfg.boost_len > BOOST_MAX) ? BOOST_MAX : cfg.boost_len;
    cd_load    = (diff > cfg.jump_thr) ? blen_sat : cd_r;
    above_rate = in_count_rate > cfg.rate_thr;
    use_fast   = (cd_load != '0) || above_rate;
    alpha_sel  = use_fast ? cfg.fast_alpha : cfg.slow_alpha;
    alpha_clamp = (alpha_sel > ALPHA_ONE) ? ALPHA_ONE : alpha_sel;
  end

  // blend of the two products with rounding
  assign sum = {1'b0, p1_r} + {1'b0, p2_r, 16'b0} + 50'd32768;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          if (in_action == ACT_CLEAR || !primed_r) state_nxt = F_PUSH;
          else state_nxt = F_MULA;
        end
      end
      F_MULA: state_nxt = F_MULB;
      F_MULB: state_nxt = F_SUM;
      F_SUM:  state_nxt = F_PUSH;
      F_PUSH: begin
        if (!q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      avg_r    <= '0;
      prev_r   <= '0;
      cd_r     <= '0;
      primed_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        if (in_action == ACT_CLEAR) begin
          avg_r    <= '0;
          prev_r   <= '0;
          cd_r     <= '0;
          primed_r <= 1'b0;
        end else if (!primed_r) begin
          avg_r    <= {in_count_rate, 16'b0};
          prev_r   <= in_count_rate;
          primed_r <= 1'b1;
        end else begin
          prev_r <= in_count_rate;
          cd_r   <= (cd_load != '0) ? cd_load - 10'd1 : cd_load;
        end
      end
      if (state_r == F_SUM) avg_r <= sum[47:16];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r     <= in_count_rate;
      alpha_r <= alpha_clamp;
      fast_r  <= use_fast;
      if (in_action == ACT_CLEAR) begin
        job_r <= '0;
      end else begin
        job_r.average <= {in_count_rate, 16'b0};
        job_r.fast    <= above_rate;
        job_r.boost   <= cd_r;
      end
    end
    if (state_r == F_MULA) p1_r <= avg_r * (ALPHA_ONE - alpha_r);
    if (state_r == F_MULB) p2_r <= x_r * alpha_r;
    if (state_r == F_SUM) begin
      job_r.average <= sum[47:16];
      job_r.fast    <= fast_r;
      job_r.boost   <= cd_r;
    end
  end

  assign q_push = (state_r == F_PUSH) && !q_full;
  assign q_data = job_r;

`ifndef ASSERT_OFF
  a_boost_bound: assert property (@(posedge clk) disable iff (!rst_n) cd_r <= BOOST_MAX)
    else $error("boost countdown above its maximum");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_full)
    else $error("front took no time for an accepted item");
`endif

endmodule

// ===== rtl/gewma_fifo.sv =====
`timescale 1ns / 1ps
// gewma_fifo: short job queue between the filter front and the dose back
// depends on gewma_pkg
module gewma_fifo import gewma_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  dose_job_t data_in,
  input  logic      pop,
  output logic      empty,
  output dose_job_t data_out
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  dose_job_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt_r == CNT_FULL);
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign data_out = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= data_in;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CNT_FULL)
    else $error("queue fill count beyond depth");
`endif

endmodule

// ===== rtl/gewma_back.sv =====
`timescale 1ns / 1ps
// gewma_back: turns queued averages into dose rates with a bit-serial divider
// and holds the result in an output register; depends on gewma_pkg
module gewma_back import gewma_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [SENS_W-1:0]  sens,
  output logic               q_pop,
  input  logic               q_empty,
  input  dose_job_t          q_data,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [AVG_W-1:0]   out_average_rate,
  output logic [AVG_W-1:0]   out_dose_level,
  output logic               out_fast_mode,
  output logic [BOOST_W-1:0] out_boost_left
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_MUL  = 5'b00010,
    B_LOAD = 5'b00100,
    B_DIV  = 5'b01000,
    B_DONE = 5'b10000
  } back_state_t;

  back_state_t            state_r, state_nxt;
  dose_job_t              job_r;
  logic [PROD_W-1:0]      prod_r;
  logic [DVD_W-1:0]       dvd_r;
  logic [SENS_W-1:0]      rem_r;
  logic [DIV_CNT_W-1:0]   cnt_r;
  logic                   out_valid_r;
  logic [AVG_W-1:0]       avg_out_r;
  logic [AVG_W-1:0]       dose_out_r;
  logic                   fast_out_r;
  logic [BOOST_W-1:0]     boost_out_r;

  logic                   out_load;
  logic [SENS_W:0]        trial;
  logic                   ge;
  logic [SENS_W:0]        trial_sub;
  logic [AVG_W-1:0]       dose_sat;

  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign out_load = (state_r == B_DONE) && (!out_valid_r || out_pop);

  // one quotient bit per cycle
  assign trial     = {rem_r, dvd_r[DVD_W-1]};
  assign ge        = trial >= {1'b0, sens};
  assign trial_sub = trial - {1'b0, sens};
  assign dose_sat  = (|dvd_r[DVD_W-1:AVG_W]) ? '1 : dvd_r[AVG_W-1:0];

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_pop) state_nxt = (sens == '0) ? B_DONE : B_MUL;
      end
      B_MUL:  state_nxt = B_LOAD;
      B_LOAD: state_nxt = B_DIV;
      B_DIV: begin
        if (cnt_r == '0) state_nxt = B_DONE;
      end
      B_DONE: begin
        if (out_load) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_pop) out_valid_r <= 1'b0;
    end
  end

  // divider datapath and output register
  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (q_pop) begin
          job_r <= q_data;
          dvd_r <= '0;
        end
      end
      B_MUL: prod_r <= job_r.average * DOSE_SCALE;
      B_LOAD: begin
        dvd_r <= {1'b0, prod_r} + DVD_W'(sens >> 1);
        rem_r <= '0;
        cnt_r <= DIV_LAST;
      end
      B_DIV: begin
        rem_r <= ge ? trial_sub[SENS_W-1:0] : trial[SENS_W-1:0];
        dvd_r <= {dvd_r[DVD_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
      end
      B_DONE: begin
        if (out_load) begin
          avg_out_r   <= job_r.average;
          dose_out_r  <= dose_sat;
          fast_out_r  <= job_r.fast;
          boost_out_r <= job_r.boost;
        end
      end
      default: ;
    endcase
  end

  assign out_empty        = !out_valid_r;
  assign out_average_rate = avg_out_r;
  assign out_dose_level   = dose_out_r;
  assign out_fast_mode    = fast_out_r;
  assign out_boost_left   = boost_out_r;

`ifndef ASSERT_OFF
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (cnt_r <= DIV_LAST))
    else $error("divider step count out of range");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop) |=> out_valid_r)
    else $error("result dropped before it was taken");
`endif

endmodule

// ===== rtl/geiger_adaptive_ewma_dose_rate_top.sv =====
`timescale 1ns / 1ps
// geiger_adaptive_ewma_dose_rate_top: configuration registers and the
// front / queue / back split; depends on gewma_pkg and the gewma_* modules
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   input    | in_push, in_full   | in_action, in_count_rate
//   result   | out_pop, out_empty | out_average_rate, out_dose_level,
//            |                    | out_fast_mode, out_boost_left
//   config   | cfg_we             | cfg_index, cfg_data
//
// the front takes a new item only after the last one is queued (a filter
// update uses a 32x17 and a 16x17 multiply in turn); the back is bound
// by the one-bit-per-cycle dose divider (47 steps), which sets the
// sustained rate; only zero sensitivity skips the divider
// reset is synchronous, active low; no clearing pass; the queue and output
// register let either side stall briefly; a full queue holds the front
module geiger_adaptive_ewma_dose_rate_top import gewma_pkg::*; #(
  parameter int DEFAULT_SENSITIVITY = 38400,
  parameter int QUEUE_DEPTH         = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_action,
  input  logic [SAMPLE_W-1:0]   in_count_rate,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [AVG_W-1:0]      out_average_rate,
  output logic [AVG_W-1:0]      out_dose_level,
  output logic                  out_fast_mode,
  output logic [BOOST_W-1:0]    out_boost_left,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  filt_cfg_t          cfg_r;
  logic [SENS_W-1:0]  sens_r;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  dose_job_t          q_wdata;
  dose_job_t          q_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rate_thr   <= RST_RATE_THR;
      cfg_r.jump_thr   <= RST_JUMP_THR;
      cfg_r.slow_alpha <= RST_SLOW_ALPHA;
      cfg_r.fast_alpha <= RST_FAST_ALPHA;
      cfg_r.boost_len  <= RST_BOOST_LEN;
      sens_r           <= SENS_W'(DEFAULT_SENSITIVITY);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RATE_THR:   cfg_r.rate_thr   <= cfg_data[SAMPLE_W-1:0];
        REG_JUMP_THR:   cfg_r.jump_thr   <= cfg_data[SAMPLE_W-1:0];
        REG_SLOW_ALPHA: cfg_r.slow_alpha <= cfg_data[ALPHA_W-1:0];
        REG_FAST_ALPHA: cfg_r.fast_alpha <= cfg_data[ALPHA_W-1:0];
        REG_BOOST_LEN:  cfg_r.boost_len  <= cfg_data[BOOST_W-1:0];
        REG_SENS:       sens_r           <= cfg_data[SENS_W-1:0];
        default: ;
      endcase
    end
  end

  // filter front
  gewma_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_action     (in_action),
    .in_count_rate (in_count_rate),
    .cfg           (cfg_r),
    .q_push        (q_push),
    .q_full        (q_full),
    .q_data        (q_wdata)
  );

  // job queue
  gewma_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .full     (q_full),
    .data_in  (q_wdata),
    .pop      (q_pop),
    .empty    (q_empty),
    .data_out (q_rdata)
  );

  // dose back
  gewma_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .sens             (sens_r),
    .q_pop            (q_pop),
    .q_empty          (q_empty),
    .q_data           (q_rdata),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_average_rate (out_average_rate),
    .out_dose_level   (out_dose_level),
    .out_fast_mode    (out_fast_mode),
    .out_boost_left   (out_boost_left)
  );

endmodule

// ===== sim/geiger_adaptive_ewma_dose_rate_top_tb.sv =====
`timescale 1ns / 1ps
// geiger_adaptive_ewma_dose_rate_top_tb: self-checking bench for the adaptive ewma
// dose-rate filter; needs gewma_pkg and geiger_adaptive_ewma_dose_rate_top

module geiger_adaptive_ewma_dose_rate_top_tb;
  import gewma_pkg::*;

  localparam int          SENS_AT_RESET = 38400;
  localparam int          SETTLE_CYCLES = 64;
  localparam int          IDLE_PCT      = 38;
  localparam logic [63:0] DOSE_CAP      = 64'hFFFF_FFFF;

  // one expected result item
  typedef struct packed {
    logic [AVG_W-1:0]   average;
    logic [AVG_W-1:0]   dose;
    logic               fast;
    logic [BOOST_W-1:0] boost;
  } dose_result_t;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_push       = 1'b0;
  logic                  in_full;
  logic                  in_action     = ACT_UPDATE;
  logic [SAMPLE_W-1:0]   in_count_rate = '0;
  logic                  out_empty;
  logic                  out_pop       = 1'b0;
  logic [AVG_W-1:0]      out_average_rate;
  logic [AVG_W-1:0]      out_dose_level;
  logic                  out_fast_mode;
  logic [BOOST_W-1:0]    out_boost_left;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  // register mirror, starts at the reset values
  logic [SAMPLE_W-1:0] shadow_rate_thr  = RST_RATE_THR;
  logic [SAMPLE_W-1:0] shadow_jump_thr  = RST_JUMP_THR;
  logic [ALPHA_W-1:0]  shadow_slow      = RST_SLOW_ALPHA;
  logic [ALPHA_W-1:0]  shadow_fast      = RST_FAST_ALPHA;
  logic [BOOST_W-1:0]  shadow_boost_len = RST_BOOST_LEN;
  logic [SENS_W-1:0]   shadow_sens      = SENS_W'(SENS_AT_RESET);

  // filter state mirror
  logic [AVG_W-1:0]    flt_avg    = '0;
  logic [SAMPLE_W-1:0] flt_prev   = '0;
  logic [BOOST_W-1:0]  flt_boost  = '0;
  logic                flt_primed = 1'b0;

  dose_result_t pending_results[$];
  dose_result_t head_result;
  int           error_count = 0;
  logic         calm        = 1'b0;
  int           walk_point  = 0;

  geiger_adaptive_ewma_dose_rate_top #(
    .DEFAULT_SENSITIVITY(SENS_AT_RESET)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_action(in_action),
    .in_count_rate(in_count_rate),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_average_rate(out_average_rate),
    .out_dose_level(out_dose_level),
    .out_fast_mode(out_fast_mode),
    .out_boost_left(out_boost_left),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // filter update and dose for one item, advances the state mirror
  function automatic dose_result_t advance_filter(logic act, logic [SAMPLE_W-1:0] x);
    dose_result_t        r;
    logic [SAMPLE_W-1:0] diff;
    logic [ALPHA_W-1:0]  a;
    logic [63:0]         acc;
    logic [63:0]         q;
    r = '0;
    if (act == ACT_CLEAR) begin
      flt_avg    = '0;
      flt_prev   = '0;
      flt_boost  = '0;
      flt_primed = 1'b0;
      return r;
    end
    if (!flt_primed) begin
      // first sample loads the average directly
      flt_avg    = {x, 16'h0000};
      flt_prev   = x;
      flt_primed = 1'b1;
      r.fast     = (x > shadow_rate_thr);
    end else begin
      diff = (x > flt_prev) ? x - flt_prev : flt_prev - x;
      if (diff > shadow_jump_thr) begin
        flt_boost = (shadow_boost_len > BOOST_MAX) ? BOOST_MAX : shadow_boost_len;
      end
      if (flt_boost != '0) begin
        r.fast    = 1'b1;
        flt_boost = flt_boost - 1'b1;
      end else begin
        r.fast = (x > shadow_rate_thr);
      end
      a = r.fast ? shadow_fast : shadow_slow;
      if (a > ALPHA_ONE) begin
        a = ALPHA_ONE;
      end
      acc = 64'(flt_avg) * 64'(ALPHA_ONE - a) + (64'(x) << 16) * 64'(a) + 64'd32768;
      flt_avg  = acc[47:16];
      flt_prev = x;
    end
    r.average = flt_avg;
    if (shadow_sens != '0) begin
      q = (64'(flt_avg) * 64'(DOSE_SCALE) + 64'(shadow_sens >> 1)) / 64'(shadow_sens);
      r.dose = (q > DOSE_CAP) ? '1 : q[AVG_W-1:0];
    end
    r.boost = flt_boost;
    return r;
  endfunction

  // random register value: ends, beyond the range, full range or a common band
  function automatic int unsigned pick_value(int unsigned lo, int unsigned hi,
                                             int unsigned common_hi, int unsigned top);
    case ($urandom_range(9))
      0: return lo;
      1: return hi;
      2: return (top > hi) ? $urandom_range(top, hi + 1) : hi;
      3, 4: return $urandom_range(hi, lo);
      default: return $urandom_range(common_hi, lo);
    endcase
  endfunction

  // send one item, with random idle cycles ahead of it unless calm is set
  task automatic push_item(logic act, logic [SAMPLE_W-1:0] rate);
    int gap;
    gap = 0;
    if (!calm) begin
      while (gap < 12 && $urandom_range(99) < IDLE_PCT) gap++;
    end
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push       <= 1'b1;
    in_action     <= act;
    in_count_rate <= rate;
    do @(posedge clk); while (in_full);
    pending_results.push_back(advance_filter(act, rate));
  endtask

  // stop sending and wait until every expected result is in
  task automatic settle();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_RATE_THR:   shadow_rate_thr  = value[SAMPLE_W-1:0];
      REG_JUMP_THR:   shadow_jump_thr  = value[SAMPLE_W-1:0];
      REG_SLOW_ALPHA: shadow_slow      = value[ALPHA_W-1:0];
      REG_FAST_ALPHA: shadow_fast      = value[ALPHA_W-1:0];
      REG_BOOST_LEN:  shadow_boost_len = value[BOOST_W-1:0];
      REG_SENS:       shadow_sens      = value[SENS_W-1:0];
      default: ;
    endcase
  endtask

  // write all six registers, block must be idle
  task automatic apply_settings(int unsigned rate_thr, int unsigned jump_thr,
                                int unsigned slow, int unsigned fast,
                                int unsigned boost_len, int unsigned sens);
    write_reg(REG_RATE_THR, CFG_DATA_W'(rate_thr));
    write_reg(REG_JUMP_THR, CFG_DATA_W'(jump_thr));
    write_reg(REG_SLOW_ALPHA, CFG_DATA_W'(slow));
    write_reg(REG_FAST_ALPHA, CFG_DATA_W'(fast));
    write_reg(REG_BOOST_LEN, CFG_DATA_W'(boost_len));
    write_reg(REG_SENS, CFG_DATA_W'(sens));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly a random walk around the last sample, plus clears and wild values
  task automatic random_items(int count);
    int unsigned roll;
    int          span;
    int          target;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        push_item(ACT_CLEAR, 16'($urandom));
      end else begin
        if (roll < 14) begin
          target = $urandom_range(65535);
        end else if (roll < 20) begin
          target = $urandom_range(1) ? 0 : 65535;
        end else if (roll < 28) begin
          target = int'(shadow_rate_thr) + int'($urandom_range(1));
        end else begin
          span = int'(shadow_jump_thr) + 2;
          if (span > 3000) span = 3000;
          target = walk_point + ($urandom_range(1) ? int'($urandom_range(span))
                                                   : -int'($urandom_range(span)));
        end
        if (target < 0) target = 0;
        if (target > 65535) target = 65535;
        walk_point = target;
        push_item(ACT_UPDATE, 16'(target));
      end
    end
  endtask

  // clear on an empty filter, first sample low and high
  task automatic test_clear_and_first_sample();
    push_item(ACT_CLEAR, 16'hFFFF);
    push_item(ACT_UPDATE, 16'd0);
    push_item(ACT_UPDATE, 16'd5);
    push_item(ACT_CLEAR, 16'd0);
    push_item(ACT_UPDATE, 16'hFFFF);
    push_item(ACT_UPDATE, 16'hFFFF);
  endtask

  // jumps around the delta threshold with reset settings
  task automatic test_jump_boost();
    push_item(ACT_UPDATE, 16'd100);
    push_item(ACT_UPDATE, 16'd100);
    push_item(ACT_UPDATE, 16'd111);
    push_item(ACT_UPDATE, 16'd101);
    push_item(ACT_UPDATE, 16'd0);
    push_item(ACT_CLEAR, 16'h5555);
    push_item(ACT_UPDATE, 16'hAAAA);
    settle();
  endtask

  // zero weight holds, weight above one, long boost, zero sensitivity
  task automatic test_weight_limits();
    apply_settings(65535, 65535, 0, 17'h1FFFF, 10'h3FF, 0);
    push_item(ACT_CLEAR, 16'd0);
    push_item(ACT_UPDATE, 16'd40000);
    push_item(ACT_UPDATE, 16'd0);
    push_item(ACT_UPDATE, 16'hFFFF);
    settle();
    apply_settings(0, 0, 0, 17'h1FFFF, 10'h3FF, 0);
    push_item(ACT_UPDATE, 16'd1);
    push_item(ACT_UPDATE, 16'd0);
    settle();
  endtask

  // threshold ends, tiny weight, dose saturation and largest sensitivity
  task automatic test_threshold_extremes();
    apply_settings(0, 65535, 65536, 1, 0, 1);
    push_item(ACT_UPDATE, 16'hFFFF);
    push_item(ACT_UPDATE, 16'd0);
    push_item(ACT_UPDATE, 16'd1);
    settle();
    apply_settings(RST_RATE_THR, RST_JUMP_THR, RST_SLOW_ALPHA, RST_FAST_ALPHA, 600, 24'hFFFFFF);
    push_item(ACT_UPDATE, 16'hFFFF);
    push_item(ACT_UPDATE, 16'hFFFF);
    push_item(ACT_CLEAR, 16'd0);
    settle();
  endtask

  // random settings per phase, random items in between
  task automatic test_random_settings();
    for (int p = 0; p < 7; p++) begin
      apply_settings(pick_value(0, 65535, 400, 65535),
                     pick_value(0, 65535, 60, 65535),
                     pick_value(0, 65536, 65536, 131071),
                     pick_value(0, 65536, 65536, 131071),
                     pick_value(0, 600, 40, 1023),
                     pick_value(0, 16777215, 60000, 16777215));
      random_items(125);
      settle();
    end
  endtask

  // both sides at full rate for a long stretch
  task automatic test_no_idle();
    calm = 1'b1;
    apply_settings(RST_RATE_THR, RST_JUMP_THR, RST_SLOW_ALPHA, RST_FAST_ALPHA,
                   RST_BOOST_LEN, SENS_AT_RESET);
    random_items(200);
    settle();
    calm = 1'b0;
  endtask

  // result checker and random pop
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: average_rate %0h", out_average_rate);
        error_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (out_average_rate !== head_result.average) begin
          $error("average_rate: expected %0h, got %0h", head_result.average, out_average_rate);
          error_count++;
        end
        if (out_dose_level !== head_result.dose) begin
          $error("dose_level: expected %0h, got %0h", head_result.dose, out_dose_level);
          error_count++;
        end
        if (out_fast_mode !== head_result.fast) begin
          $error("fast_mode: expected %0h, got %0h", head_result.fast, out_fast_mode);
          error_count++;
        end
        if (out_boost_left !== head_result.boost) begin
          $error("boost_left: expected %0d, got %0d", head_result.boost, out_boost_left);
          error_count++;
        end
      end
    end
    out_pop <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // test sequence
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_clear_and_first_sample();
    test_jump_boost();
    test_weight_limits();
    test_threshold_extremes();
    test_random_settings();
    test_no_idle();
    settle();
    if (error_count == 0) begin
      $display("geiger_adaptive_ewma_dose_rate_top_tb: done, clean");
    end else begin
      $display("geiger_adaptive_ewma_dose_rate_top_tb: done, errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("geiger_adaptive_ewma_dose_rate_top_tb: done, errors");
    $finish;
  end

endmodule
